@@ rtl/core/ccr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ccr_pkg;
    localparam int MaxPoints  = 64;
    localparam int IdxW       = 6;
    localparam int CoordW     = 32;
    localparam int FracW      = 16;
    localparam int CntW       = 7;
    localparam int AccW       = 40;
    localparam int PointW     = 3 * CoordW;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic           wr_en;
        logic [IdxW-1:0] wr_addr;
        logic           rd_en;
        logic [IdxW-1:0] rd_addr;
        logic [1:0]     tap_sel;   // which of P0..P3 the read data lands in
        logic           tap_load;
        logic           coef_load; // form c0..c3 from taps
        logic           step_en;   // one Horner step on all lanes
        logic [2:0]     step_num;  // 0..2 step index
        logic           out_load;  // halve, saturate, register result
    } ccr_cmd_t;

    typedef logic signed [AccW-1:0] acc_t;

    // v*t/2^FracW rounded, ties away from zero
    function automatic acc_t mul_frac(input acc_t a, input logic [FracW-1:0] t);
        logic             neg;
        logic [AccW-1:0]  mag;
        logic [AccW+FracW-1:0] prod;
        logic [AccW-1:0]  q;
        begin
            neg  = a[AccW-1];
            mag  = neg ? (~a + 1'b1) : a;
            prod = mag * t + (AccW+FracW)'(1 << (FracW - 1));
            q    = prod[AccW+FracW-1:FracW];
            mul_frac = neg ? acc_t'(~q + 1'b1) : acc_t'(q);
        end
    endfunction

    function automatic logic [CoordW-1:0] halve_sat(input acc_t v);
        logic [AccW-1:0] mag;
        logic [AccW-1:0] h;
        acc_t r;
        begin
            mag = v[AccW-1] ? (~v + 1'b1) : v;
            h   = (mag + 1'b1) >> 1;
            r   = v[AccW-1] ? acc_t'(~h + 1'b1) : acc_t'(h);
            if (r > acc_t'({1'b0, {(CoordW-1){1'b1}}}))
                halve_sat = {1'b0, {(CoordW-1){1'b1}}};
            else if (r < -acc_t'({1'b0, {(CoordW-1){1'b1}}}) - 1)
                halve_sat = {1'b1, {(CoordW-1){1'b0}}};
            else
                halve_sat = r[CoordW-1:0];
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/ccr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ccr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [$clog2(Depth)-1:0]  wr_addr,
    input  wire [Width-1:0]          wr_data,
    input  wire                      rd_en,
    input  wire [$clog2(Depth)-1:0]  rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

@@ rtl/core/ccr_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ccr_datapath (
    input  wire                         aclk,
    input  ccr_pkg::ccr_cmd_t           cmd,
    input  wire [ccr_pkg::PointW-1:0]   wr_point,
    input  wire [ccr_pkg::FracW-1:0]    t_in,
    input  wire                         t_load,
    output logic [6*ccr_pkg::CoordW-1:0] result
);
    import ccr_pkg::*;

    logic [PointW-1:0]    rd_data;
    logic [FracW-1:0]     t_reg;
    logic [PointW-1:0]    tap_reg [4];
    acc_t c1_reg [3], c2_reg [3], c3_reg [3];
    acc_t h_reg [3], g_reg [3];

    ccr_ram #(.Width(PointW), .Depth(MaxPoints)) u_store (
        .aclk, .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr), .wr_data(wr_point),
        .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data(rd_data)
    );

    // local t
    always_ff @(posedge aclk) begin
        if (t_load) t_reg <= t_in;
    end

    // point taps
    always_ff @(posedge aclk) begin
        if (cmd.tap_load) tap_reg[cmd.tap_sel] <= rd_data;
    end

    // coefficients and Horner steps, one lane per axis
    for (genvar k = 0; k < 3; k++) begin : g_lane
        acc_t p0, p1, p2, p3;
        acc_t mh, mg;
        assign p0 = acc_t'($signed(tap_reg[0][k*CoordW +: CoordW]));
        assign p1 = acc_t'($signed(tap_reg[1][k*CoordW +: CoordW]));
        assign p2 = acc_t'($signed(tap_reg[2][k*CoordW +: CoordW]));
        assign p3 = acc_t'($signed(tap_reg[3][k*CoordW +: CoordW]));
        assign mh = mul_frac(h_reg[k], t_reg);
        assign mg = mul_frac(g_reg[k], t_reg);

        always_ff @(posedge aclk) begin
            if (cmd.coef_load) begin
                h_reg[k]  <= -p0 + 3*p1 - 3*p2 + p3;
                g_reg[k]  <= 3*(-p0 + 3*p1 - 3*p2 + p3);
                c1_reg[k] <= 2*p0 - 5*p1 + 4*p2 - p3;
                c2_reg[k] <= p2 - p0;
                c3_reg[k] <= 2*p1;
            end else if (cmd.step_en) begin
                case (cmd.step_num)
                    3'd0: begin
                        h_reg[k] <= mh + c1_reg[k];
                        g_reg[k] <= mg + 2*c1_reg[k];
                    end
                    3'd1: begin
                        h_reg[k] <= mh + c2_reg[k];
                        g_reg[k] <= mg + c2_reg[k];
                    end
                    default: h_reg[k] <= mh + c3_reg[k];
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.out_load) begin
                result[k*CoordW +: CoordW]       <= halve_sat(h_reg[k]);
                result[(3+k)*CoordW +: CoordW]   <= halve_sat(g_reg[k]);
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/ccr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ccr_ctrl (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire                        in_op,
    input  wire [ccr_pkg::IdxW-1:0]    in_slot,
    input  wire [ccr_pkg::FracW-1:0]   in_frac,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire [ccr_pkg::CntW-1:0]    cfg_data,
    output logic                       out_valid,
    input  wire                        out_ready,
    output ccr_pkg::ccr_cmd_t          cmd,
    output logic [ccr_pkg::FracW-1:0]  t_out,
    output logic                       t_load
);
    import ccr_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_COEF = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic [CntW-1:0] count_reg;
    logic [IdxW-1:0] n_m1, addr_reg, addr_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [CntW-1:0] n_eff;
    logic [CntW+FracW-1:0] s;
    logic            busy_out_reg;
    logic            in_acc;

    assign n_eff = (count_reg == '0) ? CntW'(1) :
                   (count_reg > CntW'(MaxPoints)) ? CntW'(MaxPoints) : count_reg;
    assign n_m1    = IdxW'(n_eff - 1'b1);
    assign s       = in_frac * n_eff;
    assign t_out   = s[FracW-1:0];
    assign in_ready = (state_reg == ST_IDLE) && !busy_out_reg;
    assign in_acc   = in_valid && in_ready;
    assign t_load   = in_acc && (in_op == OP_EVAL);
    assign cfg_ready = 1'b1;
    assign out_valid = busy_out_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.wr_addr = in_slot;
        cmd.rd_addr = addr_reg;
        cmd.tap_sel = cnt_reg[1:0] - 2'd1;
        cmd.step_num = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && in_op == OP_LOAD) cmd.wr_en = 1'b1;
                if (t_load) begin
                    // P0 sits one before the segment, modulo n
                    addr_next = (s[CntW+FracW-1:FracW] == '0) ? n_m1 :
                                IdxW'(s[CntW+FracW-1:FracW] - 1'b1);
                    cnt_next  = 3'd0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en   = (cnt_reg < 3'd4);
                cmd.tap_load = (cnt_reg != 3'd0);
                addr_next = (addr_reg == n_m1) ? '0 : addr_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 3'd4) state_next = ST_COEF;
            end
            ST_COEF: begin
                cmd.coef_load = 1'b1;
                cnt_next   = 3'd0;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.step_en = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd2) state_next = ST_OUT;
            end
            ST_OUT: begin
                cmd.out_load = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= CntW'(4);
            busy_out_reg <= 1'b0;
            addr_reg     <= '0;
            cnt_reg      <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid) count_reg <= cfg_data;
            if (cmd.out_load) busy_out_reg <= 1'b1;
            else if (out_ready) busy_out_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/closed_catmull_rom_evaluator_top.sv @@
// Load: the point is written to the store on accept. Evaluate, from accept to
// m_tvalid: four store reads through the registered RAM read port, coefficient
// build, three Horner steps with one position multiply-round per axis in each
// and one derivative multiply-round per axis in the first two, halve/saturate.
// One item at a time; the next is accepted once the result has been taken.
// aresetn synchronous active low: point_count returns to 4; store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module closed_catmull_rom_evaluator_top (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // tdata: point_slot[5:0], point_x[37:6], point_y[69:38], point_z[101:70],
    // loop_fraction[117:102], zero fill to 120
    input  wire [119:0]  s_tdata,
    input  wire          s_tuser,   // opcode
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire [6:0]    cfg_data,
    output logic         m_tvalid,
    input  wire          m_tready,
    // tdata: pos_x, pos_y, pos_z, tangent_x, tangent_y, tangent_z, 32 bits each
    output logic [191:0] m_tdata
);
    import ccr_pkg::*;

    ccr_cmd_t         cmd;
    logic [FracW-1:0] t_loc;
    logic             t_load;

    ccr_ctrl u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser),
        .in_slot(s_tdata[5:0]), .in_frac(s_tdata[117:102]),
        .cfg_valid, .cfg_ready, .cfg_data,
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd, .t_out(t_loc), .t_load
    );

    ccr_datapath u_dp (
        .aclk, .cmd, .wr_point(s_tdata[101:6]), .t_in(t_loc), .t_load,
        .result(m_tdata)
    );
endmodule
`default_nettype wire

@@ rtl/core/ccr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ccr_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         s_tuser,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [191:0] m_tdata
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed under stall");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while result pending");
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("ready right after evaluate");
    a_load_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> !m_tvalid)
        else $error("load produced a result");
endmodule
bind closed_catmull_rom_evaluator_top ccr_checker u_chk (.*);
`default_nettype wire
